// File: sv/mwf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the 3x3 median window filter.
package mwf_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 24;
	localparam int CFG_BITS       = 11;
	localparam int RESET_WIDTH    = 640;
	localparam int MIN_WIDTH      = 3;
	localparam int FIRST_EMIT_COL = 2;

	localparam logic [1:0] ROWS_FULL = 2'd2;

	// Per-stage control travelling alongside the pixel data
	typedef struct packed {
		logic valid;
		logic emit;
		logic eoi;
	} mwf_ctrl_t;

endpackage

// File: sv/mwf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel input and filter results.
interface mwf_pix_if #(
	parameter int PIXEL_BITS = 24
) ();
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pixel_value;
	logic                         end_of_image;

	modport source (output valid, output pixel_value, output end_of_image, input ready);
	modport sink   (input valid, input pixel_value, input end_of_image, output ready);
endinterface

interface mwf_res_if #(
	parameter int PIXEL_BITS = 24
) ();
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] median_value;
	logic                         image_done;

	modport source (output valid, output median_value, output image_done, input ready);
	modport sink   (input valid, input median_value, input image_done, output ready);
endinterface

// File: sv/mwf_line_buffer.sv
`timescale 1ns / 1ps
// Two-row line memory, one read and one write per cycle, registered read with write bypass.
module mwf_line_buffer #(
	parameter int DEPTH     = 1024,
	parameter int DATA_BITS = 48
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_BITS-1:0]     wdata,
	output logic [DATA_BITS-1:0]     rdata
);

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [DATA_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en && wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (en && rd_en) begin
			// same-address write in this cycle: take the new word
			if (wr_en && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem_q[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/mwf_window_median.sv
`timescale 1ns / 1ps
// 3x3 window of sorted columns and the two-stage median-of-nine network.
module mwf_window_median import mwf_pkg::*; #(
	parameter int PIXEL_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  mwf_ctrl_t                    ctrl_s1,
	input  logic signed [PIXEL_BITS-1:0] upper_s1,
	input  logic signed [PIXEL_BITS-1:0] middle_s1,
	input  logic signed [PIXEL_BITS-1:0] pixel_s1,
	output mwf_ctrl_t                    ctrl_out,
	output logic signed [PIXEL_BITS-1:0] median_out
);

	typedef logic signed [PIXEL_BITS-1:0] pix_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	pix_t      col_lo, col_md, col_hi;
	pix_t      lo_q [3];
	pix_t      md_q [3];
	pix_t      hi_q [3];
	mwf_ctrl_t ctrl_s2, ctrl_s3;
	pix_t      lo_max_s3, md_med_s3, hi_min_s3;

	// sort the incoming column
	always_comb begin
		col_lo = min2(min2(upper_s1, middle_s1), pixel_s1);
		col_hi = max2(max2(upper_s1, middle_s1), pixel_s1);
		col_md = med3(upper_s1, middle_s1, pixel_s1);
	end

	always_ff @(posedge clk) begin
		if (en && ctrl_s1.valid && !ctrl_s1.eoi) begin
			lo_q[0] <= lo_q[1];
			lo_q[1] <= lo_q[2];
			lo_q[2] <= col_lo;
			md_q[0] <= md_q[1];
			md_q[1] <= md_q[2];
			md_q[2] <= col_md;
			hi_q[0] <= hi_q[1];
			hi_q[1] <= hi_q[2];
			hi_q[2] <= col_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_max_s3 <= max2(max2(lo_q[0], lo_q[1]), lo_q[2]);
			md_med_s3 <= med3(md_q[0], md_q[1], md_q[2]);
			hi_min_s3 <= min2(min2(hi_q[0], hi_q[1]), hi_q[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_comb begin
		ctrl_out   = ctrl_s3;
		median_out = ctrl_s3.eoi ? '0 : med3(lo_max_s3, md_med_s3, hi_min_s3);
	end

endmodule

// File: sv/mwf_out_skid.sv
`timescale 1ns / 1ps
// Output register with a skid stage so upstream ready does not follow the sink combinationally.
module mwf_out_skid import mwf_pkg::*; #(
	parameter int PIXEL_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [PIXEL_BITS-1:0] in_median,
	input  logic                         in_done,
	output logic                         advance,
	mwf_res_if.source                    results
);

	logic                         out_valid_q, skid_valid_q;
	logic signed [PIXEL_BITS-1:0] out_median_q, skid_median_q;
	logic                         out_done_q, skid_done_q;
	logic                         out_free;

	assign out_free = !out_valid_q || results.ready;
	assign advance  = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_median_q <= skid_median_q;
				out_done_q   <= skid_done_q;
			end else begin
				out_median_q <= in_median;
				out_done_q   <= in_done;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_median_q <= in_median;
			skid_done_q   <= in_done;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.median_value = out_median_q;
	assign results.image_done   = out_done_q;

endmodule

// File: sv/median3x3_window_filter.sv
`timescale 1ns / 1ps
// 3x3 median filter over a raster pixel stream: top level.
// Takes one pixel per clock unless stalled and gives at most one result per clock; a result
// passes the stage-1, window and stage-3 registers to the output register. Each pixel does
// one read and one write of the line memory (MAX_WIDTH words holding the two previous rows),
// so the memory's single read port and single write port set the rate of one pixel per
// cycle. Results appear only for complete windows (third row onwards, third column onwards),
// plus one done result per end-of-image item. Ready drops only when the output is stalled
// and a second result waits in the skid stage. The line memory needs no clearing after reset.
module median3x3_window_filter import mwf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	mwf_pix_if.sink             pixels,
	mwf_res_if.source           results,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int EW    = (CFG_BITS > WW) ? CFG_BITS : WW;
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

	logic [WW-1:0]                width_q;
	logic [EW-1:0]                cfg_ext;
	logic [CW-1:0]                col_q, col_c, col_d;
	logic [1:0]                   rows_q, rows_a, rows_d;
	logic [WW-1:0]                col_next;
	logic                         wrap_in, wrap_out, emit;
	logic                         advance, accept;

	mwf_ctrl_t                    ctrl_s1, res_ctrl;
	logic signed [PIXEL_BITS-1:0] pix_s1, res_median;
	logic [CW-1:0]                addr_s1;
	logic [2*PIXEL_BITS-1:0]      line_rd;

	assign pixels.ready = advance;
	assign accept       = pixels.valid && advance;

	// width register, clamped on write
	assign cfg_ext = EW'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WW'(RST_W);
		end else if (cfg_we) begin
			if (cfg_ext < EW'(MIN_WIDTH)) begin
				width_q <= WW'(MIN_WIDTH);
			end else if (cfg_ext > EW'(MAX_WIDTH)) begin
				width_q <= WW'(MAX_WIDTH);
			end else begin
				width_q <= cfg_ext[WW-1:0];
			end
		end
	end

	// column / row tracking
	always_comb begin
		wrap_in  = WW'(col_q) >= width_q;
		col_c    = wrap_in ? '0 : col_q;
		rows_a   = (wrap_in && (rows_q != ROWS_FULL)) ? rows_q + 2'd1 : rows_q;
		emit     = (rows_a == ROWS_FULL) && (col_c >= CW'(FIRST_EMIT_COL));
		col_next = WW'(col_c) + WW'(1);
		wrap_out = col_next >= width_q;
		col_d    = wrap_out ? '0 : col_next[CW-1:0];
		rows_d   = (wrap_out && (rows_a != ROWS_FULL)) ? rows_a + 2'd1 : rows_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			rows_q  <= '0;
			ctrl_s1 <= '0;
		end else if (advance) begin
			ctrl_s1.valid <= accept;
			ctrl_s1.emit  <= emit && !pixels.end_of_image;
			ctrl_s1.eoi   <= pixels.end_of_image;
			if (accept) begin
				if (pixels.end_of_image) begin
					col_q  <= '0;
					rows_q <= '0;
				end else begin
					col_q  <= col_d;
					rows_q <= rows_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s1  <= pixels.pixel_value;
			addr_s1 <= col_c;
		end
	end

	// word layout: {upper row, middle row}
	mwf_line_buffer #(
		.DEPTH     (MAX_WIDTH),
		.DATA_BITS (2 * PIXEL_BITS)
	) u_line_buffer (
		.clk   (clk),
		.en    (advance),
		.rd_en (accept && !pixels.end_of_image),
		.raddr (col_c),
		.wr_en (ctrl_s1.valid && !ctrl_s1.eoi),
		.waddr (addr_s1),
		.wdata ({line_rd[PIXEL_BITS-1:0], pix_s1}),
		.rdata (line_rd)
	);

	mwf_window_median #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_window_median (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.ctrl_s1    (ctrl_s1),
		.upper_s1   ($signed(line_rd[2*PIXEL_BITS-1:PIXEL_BITS])),
		.middle_s1  ($signed(line_rd[PIXEL_BITS-1:0])),
		.pixel_s1   (pix_s1),
		.ctrl_out   (res_ctrl),
		.median_out (res_median)
	);

	mwf_out_skid #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_ctrl.valid && (res_ctrl.emit || res_ctrl.eoi)),
		.in_median (res_median),
		.in_done   (res_ctrl.eoi),
		.advance   (advance),
		.results   (results)
	);

endmodule

// File: sv/mwf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the median window filter, bound to the top level.
module mwf_checker #(
	parameter int PIXEL_BITS = 24
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [PIXEL_BITS-1:0] median_value,
	input logic                         image_done
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(median_value) && $stable(image_done)))
		else $error("result changed while stalled");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && image_done) |-> (median_value == '0))
		else $error("done transfer with non-zero median");

	// input backpressure only behind a held result
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("ready dropped without output stall");

	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> $past(out_valid && out_ready))
		else $error("ready returned without output transfer");

endmodule

bind median3x3_window_filter mwf_checker #(
	.PIXEL_BITS (PIXEL_BITS)
) u_mwf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pixels.valid),
	.in_ready     (pixels.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.median_value (results.median_value),
	.image_done   (results.image_done)
);
